### rtl/tlie_pkg.sv
// Shared codes and constants for the table interpolation core.
`timescale 1ns / 1ps

package tlie_pkg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] REGION_INSIDE = 2'd0;
    localparam logic [1:0] REGION_BELOW  = 2'd1;
    localparam logic [1:0] REGION_ABOVE  = 2'd2;
    localparam logic [1:0] REGION_FIRST  = 2'd3;

    localparam int          COUNT_W     = 9;
    localparam int          Q_W         = 32;
    localparam int          DIFF_W      = Q_W + 1;
    localparam int          PROD_W      = 2 * DIFF_W;
    localparam int          CAP_W       = 35;
    localparam int          STEP_W      = 7;

    localparam logic [STEP_W-1:0] MUL_LAST_STEP = 7'd32;
    localparam logic [STEP_W-1:0] DIV_LAST_STEP = 7'd65;

    // 2^34: largest quotient kept before the final add
    localparam logic [PROD_W-1:0] QUOT_CAP = 66'h0_0000_0004_0000_0000;

    localparam logic signed [36:0] SUM_MAX = 37'sh00_7FFF_FFFF;
    localparam logic signed [36:0] SUM_MIN = 37'sh1F_8000_0000;

endpackage

### rtl/table_linear_interp_extrap_core.sv
// Piecewise linear interpolation / extrapolation over a loaded point table.
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+-------------------
//  in      | cmd, entry_index, x_value, y_value        | in_valid/in_ready
//  out     | y_result, region, zero_interval, saturated| out_valid/out_ready
//  cfg     | cfg_wr_data (entry_count)                 | cfg_wr_en
//
// A write word is stored while idle. A query's run time is set by the
// one-entry-per-cycle table scan on the single RAM read port and the
// bit-serial multiply and divide that share one 34-bit adder. in_ready is
// high only while idle. A finished word waits in the output register; a
// later query holds in its last step until it drains.
// Async active-low reset; the table is not cleared.
`timescale 1ns / 1ps

module table_linear_interp_extrap_core #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_wr_en,
    input  logic [8:0]          cfg_wr_data,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic                cmd,
    input  logic [7:0]          entry_index,
    input  logic signed [31:0]  x_value,
    input  logic signed [31:0]  y_value,

    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  y_result,
    output logic [1:0]          region,
    output logic                zero_interval,
    output logic                saturated
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = (AW + 1 > tlie_pkg::COUNT_W) ? AW + 1 : tlie_pkg::COUNT_W;

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00_0000_0000_0001,
        S_RD_LAST  = 14'b00_0000_0000_0010,
        S_RD_FIRST = 14'b00_0000_0000_0100,
        S_DECIDE   = 14'b00_0000_0000_1000,
        S_SCAN     = 14'b00_0000_0001_0000,
        S_LOAD_A   = 14'b00_0000_0010_0000,
        S_LOAD_B   = 14'b00_0000_0100_0000,
        S_DIFF     = 14'b00_0000_1000_0000,
        S_PREP     = 14'b00_0001_0000_0000,
        S_MUL      = 14'b00_0010_0000_0000,
        S_DIV      = 14'b00_0100_0000_0000,
        S_SCALE    = 14'b00_1000_0000_0000,
        S_SUM      = 14'b01_0000_0000_0000,
        S_DONE     = 14'b10_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [8:0]          entry_count_reg;
    logic                out_valid_reg, out_valid_next;

    logic signed [31:0]  q_reg, q_next;
    logic [AW-1:0]       nl_reg, nl_next;
    logic [AW-1:0]       cur_reg, cur_next;
    logic [AW-1:0]       b_reg, b_next;
    logic signed [31:0]  xlast_reg, xlast_next;
    logic signed [31:0]  xa_reg, xa_next;
    logic signed [31:0]  ya_reg, ya_next;
    logic signed [31:0]  yb_reg, yb_next;
    logic signed [32:0]  dx_reg, dx_next;
    logic signed [32:0]  dy_reg, dy_next;
    logic signed [32:0]  t_reg, t_next;
    logic [32:0]         mcand_reg, mcand_next;
    logic [32:0]         dvsr_reg, dvsr_next;
    logic                neg_reg, neg_next;
    logic [65:0]         p_reg, p_next;
    logic [32:0]         r_reg, r_next;
    logic [6:0]          cnt_reg, cnt_next;
    logic signed [35:0]  delta_reg, delta_next;
    logic signed [31:0]  res_y_reg, res_y_next;
    logic [1:0]          res_region_reg, res_region_next;
    logic                res_zero_reg, res_zero_next;
    logic                res_sat_reg, res_sat_next;
    logic signed [31:0]  out_y_reg, out_y_next;
    logic [1:0]          out_region_reg, out_region_next;
    logic                out_zero_reg, out_zero_next;
    logic                out_sat_reg, out_sat_next;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr;
    logic [63:0]         rd_data;
    logic signed [31:0]  rd_x;
    logic signed [31:0]  rd_y;

    logic [CW-1:0]       cnt_ext;
    logic [CW-1:0]       n_clamp;

    logic                alu_sub;
    logic [33:0]         alu_a;
    logic [33:0]         alu_b;
    logic [34:0]         alu_sum;

    logic [34:0]         quot_cap;
    logic signed [36:0]  sum_full;

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign y_result      = out_y_reg;
    assign region        = out_region_reg;
    assign zero_interval = out_zero_reg;
    assign saturated     = out_sat_reg;

    assign wr_en   = in_valid && in_ready && (cmd == tlie_pkg::CMD_WRITE)
                     && (int'(entry_index) < TABLE_DEPTH);
    assign wr_addr = AW'(entry_index);

    assign rd_x = rd_data[63:32];
    assign rd_y = rd_data[31:0];

    tlie_ram #(
        .WIDTH (64),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata ({x_value, y_value}),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        cnt_ext = CW'(entry_count_reg);
        if (cnt_ext < CW'(2))
        begin
            n_clamp = CW'(2);
        end
        else if (cnt_ext > CW'(TABLE_DEPTH))
        begin
            n_clamp = CW'(TABLE_DEPTH);
        end
        else
        begin
            n_clamp = cnt_ext;
        end
    end

    always_comb
    begin
        case (state_reg)
            S_RD_LAST:  rd_addr = nl_reg;
            S_RD_FIRST: rd_addr = '0;
            S_DECIDE:   rd_addr = AW'(1);
            S_SCAN:     rd_addr = cur_reg + AW'(1);
            S_LOAD_A:   rd_addr = b_reg - AW'(1);
            S_LOAD_B:   rd_addr = b_reg;
            default:    rd_addr = '0;
        endcase
    end

    // shared adder: multiply accumulate, or trial subtract while dividing
    assign alu_sub = (state_reg == S_DIV);
    assign alu_a   = alu_sub ? {r_reg, p_reg[65]} : {1'b0, p_reg[65:33]};
    assign alu_b   = alu_sub ? {1'b0, dvsr_reg} : {1'b0, mcand_reg};
    assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {34{alu_sub}}} + 35'(alu_sub);

    assign quot_cap = (p_reg > tlie_pkg::QUOT_CAP) ? tlie_pkg::QUOT_CAP[34:0]
                                                   : p_reg[34:0];
    assign sum_full = {{5{ya_reg[31]}}, ya_reg} + {delta_reg[35], delta_reg};

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        q_next          = q_reg;
        nl_next         = nl_reg;
        cur_next        = cur_reg;
        b_next          = b_reg;
        xlast_next      = xlast_reg;
        xa_next         = xa_reg;
        ya_next         = ya_reg;
        yb_next         = yb_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        t_next          = t_reg;
        mcand_next      = mcand_reg;
        dvsr_next       = dvsr_reg;
        neg_next        = neg_reg;
        p_next          = p_reg;
        r_next          = r_reg;
        cnt_next        = cnt_reg;
        delta_next      = delta_reg;
        res_y_next      = res_y_reg;
        res_region_next = res_region_reg;
        res_zero_next   = res_zero_reg;
        res_sat_next    = res_sat_reg;
        out_y_next      = out_y_reg;
        out_region_next = out_region_reg;
        out_zero_next   = out_zero_reg;
        out_sat_next    = out_sat_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && (cmd == tlie_pkg::CMD_QUERY))
                begin
                    q_next     = x_value;
                    nl_next    = AW'(n_clamp - CW'(1));
                    state_next = S_RD_LAST;
                end
            end
            S_RD_LAST:
            begin
                state_next = S_RD_FIRST;
            end
            S_RD_FIRST:
            begin
                xlast_next = rd_x;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                res_zero_next = 1'b0;
                res_sat_next  = 1'b0;
                if (q_reg > xlast_reg)
                begin
                    res_region_next = tlie_pkg::REGION_ABOVE;
                    b_next          = nl_reg;
                    state_next      = S_LOAD_A;
                end
                else if (q_reg < rd_x)
                begin
                    res_region_next = tlie_pkg::REGION_BELOW;
                    b_next          = AW'(1);
                    state_next      = S_LOAD_A;
                end
                else if (q_reg == rd_x)
                begin
                    res_region_next = tlie_pkg::REGION_FIRST;
                    res_y_next      = rd_y;
                    state_next      = S_DONE;
                end
                else
                begin
                    res_region_next = tlie_pkg::REGION_INSIDE;
                    cur_next        = AW'(1);
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if ((cur_reg == nl_reg) || !(q_reg > rd_x))
                begin
                    b_next     = cur_reg;
                    state_next = S_LOAD_A;
                end
                else
                begin
                    cur_next = cur_reg + AW'(1);
                end
            end
            S_LOAD_A:
            begin
                state_next = S_LOAD_B;
            end
            S_LOAD_B:
            begin
                xa_next    = rd_x;
                ya_next    = rd_y;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                yb_next    = rd_y;
                dx_next    = {rd_x[31], rd_x} - {xa_reg[31], xa_reg};
                dy_next    = {rd_y[31], rd_y} - {ya_reg[31], ya_reg};
                t_next     = {q_reg[31], q_reg} - {xa_reg[31], xa_reg};
                state_next = S_PREP;
            end
            S_PREP:
            begin
                if (dx_reg == '0)
                begin
                    res_y_next    = yb_reg;
                    res_zero_next = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    mcand_next = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
                    dvsr_next  = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
                    p_next     = {33'd0, (t_reg[32] ? 33'(-t_reg) : 33'(t_reg))};
                    neg_next   = dy_reg[32] ^ t_reg[32] ^ dx_reg[32];
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                p_next   = p_reg[0] ? {alu_sum[33:0], p_reg[32:1]} : {1'b0, p_reg[65:1]};
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == tlie_pkg::MUL_LAST_STEP)
                begin
                    cnt_next   = '0;
                    r_next     = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                r_next   = alu_sum[34] ? alu_sum[32:0] : alu_a[32:0];
                p_next   = {p_reg[64:0], alu_sum[34]};
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == tlie_pkg::DIV_LAST_STEP)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                delta_next = neg_reg ? -$signed({1'b0, quot_cap})
                                     : $signed({1'b0, quot_cap});
                state_next = S_SUM;
            end
            S_SUM:
            begin
                if (sum_full > tlie_pkg::SUM_MAX)
                begin
                    res_y_next   = 32'sh7FFF_FFFF;
                    res_sat_next = 1'b1;
                end
                else if (sum_full < tlie_pkg::SUM_MIN)
                begin
                    res_y_next   = 32'sh8000_0000;
                    res_sat_next = 1'b1;
                end
                else
                begin
                    res_y_next = sum_full[31:0];
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_y_next      = res_y_reg;
                    out_region_next = res_region_reg;
                    out_zero_next   = res_zero_reg;
                    out_sat_next    = res_sat_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            entry_count_reg <= 9'd2;
            cnt_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            if (cfg_wr_en)
            begin
                entry_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg          <= q_next;
        nl_reg         <= nl_next;
        cur_reg        <= cur_next;
        b_reg          <= b_next;
        xlast_reg      <= xlast_next;
        xa_reg         <= xa_next;
        ya_reg         <= ya_next;
        yb_reg         <= yb_next;
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        t_reg          <= t_next;
        mcand_reg      <= mcand_next;
        dvsr_reg       <= dvsr_next;
        neg_reg        <= neg_next;
        p_reg          <= p_next;
        r_reg          <= r_next;
        delta_reg      <= delta_next;
        res_y_reg      <= res_y_next;
        res_region_reg <= res_region_next;
        res_zero_reg   <= res_zero_next;
        res_sat_reg    <= res_sat_next;
        out_y_reg      <= out_y_next;
        out_region_reg <= out_region_next;
        out_zero_reg   <= out_zero_next;
        out_sat_reg    <= out_sat_next;
    end

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result word appeared outside the hand-off step");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (cur_reg <= nl_reg))
        else $error("table scan ran past the last point in use");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (dvsr_reg != '0))
        else $error("divide started with a zero interval");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_zero_reg && out_sat_reg))
        else $error("zero interval and saturation flagged together");

endmodule

### rtl/tlie_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tlie_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sim/tlie_checker.sv
// Checker for the table interpolation core: shadow table, predicted result words, comparison.
`timescale 1ns / 1ps

module tlie_checker #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [8:0]         cfg_wr_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               cmd,
    input  logic [7:0]         entry_index,
    input  logic signed [31:0] x_value,
    input  logic signed [31:0] y_value,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] y_result,
    input  logic [1:0]         region,
    input  logic               zero_interval,
    input  logic               saturated,
    output int                 mismatches,
    output int                 outstanding,
    output int                 results_seen,
    output int                 sat_seen,
    output int                 zero_seen
);

    typedef struct packed {
        logic signed [31:0] y;
        logic [1:0]         region;
        logic               zero;
        logic               sat;
    } interp_word_t;

    localparam longint Q_HI = 64'sd2147483647;
    localparam longint Q_LO = -64'sd2147483648;
    localparam longint unsigned STEP_CAP = 64'd17179869184;

    logic signed [31:0] x_shadow [TABLE_DEPTH];
    logic signed [31:0] y_shadow [TABLE_DEPTH];
    logic [8:0]         points_reg = 9'd2;
    interp_word_t       expected_words [$];

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic interp_word_t along_line(input int a, input int b,
                                                input logic signed [31:0] q);
        interp_word_t w;
        longint ya, dy, dx, t, sum;
        longint unsigned quot;
        logic neg;
        w = '0;
        ya = y_shadow[a];
        dy = longint'(y_shadow[b]) - ya;
        dx = longint'(x_shadow[b]) - longint'(x_shadow[a]);
        t = longint'(q) - longint'(x_shadow[a]);
        if (dx == 0)
        begin
            w.y = y_shadow[b];
            w.zero = 1'b1;
            return w;
        end
        quot = (magnitude(dy) * magnitude(t)) / magnitude(dx);
        if (quot > STEP_CAP)
            quot = STEP_CAP;
        neg = ((dy < 0) != (t < 0)) != (dx < 0);
        sum = neg ? ya - longint'(quot) : ya + longint'(quot);
        if (sum > Q_HI)
        begin
            sum = Q_HI;
            w.sat = 1'b1;
        end
        else if (sum < Q_LO)
        begin
            sum = Q_LO;
            w.sat = 1'b1;
        end
        w.y = sum[31:0];
        return w;
    endfunction

    function automatic interp_word_t predict_point(input logic signed [31:0] q);
        interp_word_t w;
        int n, i;
        if (points_reg < 2)
            n = 2;
        else if (points_reg > TABLE_DEPTH)
            n = TABLE_DEPTH;
        else
            n = int'(points_reg);
        if (q > x_shadow[n-1])
        begin
            w = along_line(n - 2, n - 1, q);
            w.region = tlie_pkg::REGION_ABOVE;
        end
        else if (q < x_shadow[0])
        begin
            w = along_line(0, 1, q);
            w.region = tlie_pkg::REGION_BELOW;
        end
        else
        begin
            i = 0;
            while (i < n - 1 && q > x_shadow[i])
                i++;
            if (i == 0)
            begin
                w = '0;
                w.y = y_shadow[0];
                w.region = tlie_pkg::REGION_FIRST;
            end
            else
            begin
                w = along_line(i - 1, i, q);
                w.region = tlie_pkg::REGION_INSIDE;
            end
        end
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        interp_word_t want;
        if (!rst_n)
        begin
            points_reg = 9'd2;
            expected_words.delete();
            outstanding = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected result word: y=%h region=%0d zero=%b sat=%b",
                                 $realtime, y_result, region, zero_interval, saturated);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (want.sat)
                        sat_seen++;
                    if (want.zero)
                        zero_seen++;
                    if (y_result !== want.y || region !== want.region ||
                        zero_interval !== want.zero || saturated !== want.sat)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0t] exp y=%h rg=%0d z=%b s=%b got y=%h rg=%0d z=%b s=%b",
                                     $realtime, want.y, want.region, want.zero, want.sat,
                                     y_result, region, zero_interval, saturated);
                    end
                end
            end
            if (cfg_wr_en)
                points_reg = cfg_wr_data;
            if (in_valid && in_ready)
            begin
                if (cmd == tlie_pkg::CMD_QUERY)
                    expected_words.push_back(predict_point(x_value));
                else if (entry_index < TABLE_DEPTH)
                begin
                    x_shadow[entry_index] = x_value;
                    y_shadow[entry_index] = y_value;
                end
            end
            outstanding = expected_words.size();
        end
    end

endmodule

### sim/tb_table_linear_interp_extrap_core.sv
// Testbench top for the table interpolation core: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module tb_table_linear_interp_extrap_core;

    localparam int DEPTH             = 256;
    localparam int DRAIN_CYCLES      = 400;
    localparam int HOLD_CYCLES       = 1500;
    localparam int QUERIES_PER_PHASE = 16;
    localparam int PHASES            = 13;
    localparam longint LIMIT_NS      = 64'd50_000_000;

    typedef enum int {SHAPE_RAMP, SHAPE_STEPS, SHAPE_STEEP, SHAPE_SHUFFLED} table_shape_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en;
    logic [8:0]         cfg_wr_data;
    logic               in_valid;
    logic               in_ready;
    logic               cmd;
    logic [7:0]         entry_index;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] y_result;
    logic [1:0]         region;
    logic               zero_interval;
    logic               saturated;

    int mismatches, outstanding, results_seen, sat_seen, zero_seen;
    int writes_sent, queries_sent, active_points, hold_seq;
    logic calm;
    logic signed [31:0] point_x [DEPTH];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    table_linear_interp_extrap_core #(
        .TABLE_DEPTH(DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd(cmd),
        .entry_index(entry_index),
        .x_value(x_value),
        .y_value(y_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .y_result(y_result),
        .region(region),
        .zero_interval(zero_interval),
        .saturated(saturated)
    );

    tlie_checker #(
        .TABLE_DEPTH(DEPTH)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd(cmd),
        .entry_index(entry_index),
        .x_value(x_value),
        .y_value(y_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .y_result(y_result),
        .region(region),
        .zero_interval(zero_interval),
        .saturated(saturated),
        .mismatches(mismatches),
        .outstanding(outstanding),
        .results_seen(results_seen),
        .sat_seen(sat_seen),
        .zero_seen(zero_seen)
    );

    function automatic logic signed [31:0] clamp_q(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] pick_query();
        int n, j;
        longint lo, hi, span;
        n = active_points;
        j = $urandom_range(n - 2);
        lo = point_x[j];
        hi = point_x[j + 1];
        case ($urandom_range(9))
            0: return point_x[$urandom_range(n - 1)];
            1: return clamp_q(longint'(point_x[0]) - 1 - (longint'($urandom()) >> $urandom_range(31)));
            2: return clamp_q(longint'(point_x[n - 1]) + 1 + (longint'($urandom()) >> $urandom_range(31)));
            3: return $urandom();
            4: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default:
            begin
                if (hi <= lo)
                    return point_x[j];
                span = hi - lo + 1;
                return clamp_q(lo + longint'({$urandom(), $urandom()} % span));
            end
        endcase
    endfunction

    task automatic push_word(input logic c, input logic [7:0] idx,
                             input logic signed [31:0] x, input logic signed [31:0] y);
        while (!calm && $urandom_range(99) < 27)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        cmd <= c;
        entry_index <= idx;
        x_value <= x;
        y_value <= y;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (c == tlie_pkg::CMD_QUERY)
            queries_sent++;
        else
            writes_sent++;
    endtask

    task automatic put_point(input logic [7:0] idx, input logic signed [31:0] x,
                             input logic signed [31:0] y);
        point_x[idx] = x;
        push_word(tlie_pkg::CMD_WRITE, idx, x, y);
    endtask

    task automatic ask(input logic signed [31:0] q);
        push_word(tlie_pkg::CMD_QUERY, 8'($urandom()), q, $urandom());
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_count(input logic [8:0] v);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (v < 2)
            active_points = 2;
        else if (v > DEPTH)
            active_points = DEPTH;
        else
            active_points = int'(v);
    endtask

    task automatic load_table(input int n, input table_shape_t shape);
        longint xpos, step;
        int span;
        logic signed [31:0] x, y;
        span = $urandom_range(22);
        xpos = -longint'($urandom_range(32'h7FFF_FFFF));
        for (int i = 0; i < n; i++)
        begin
            case (shape)
                SHAPE_RAMP:  step = longint'($urandom_range(1 << span, 1));
                SHAPE_STEPS: step = ($urandom_range(2) == 0) ? 0 : longint'($urandom_range(1 << span));
                SHAPE_STEEP: step = longint'($urandom_range(4, 1));
                default:     step = 0;
            endcase
            if (shape == SHAPE_SHUFFLED)
                x = $urandom();
            else
                x = clamp_q(xpos);
            if (shape == SHAPE_STEEP || shape == SHAPE_SHUFFLED)
                y = $urandom();
            else
                y = $signed($urandom()) >>> $urandom_range(31);
            put_point(8'(i), x, y);
            xpos += step;
        end
    endtask

    // y-only rewrite keeps the table order intact
    task automatic refresh_y();
        int j;
        j = $urandom_range(DEPTH - 1);
        put_point(8'(j), point_x[j], $urandom());
    endtask

    initial
    begin
        int hold_left, seen;
        hold_left = 0;
        seen = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seq != seen)
            begin
                seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(99) >= 27);
        end
    end

    initial
    begin
        #(LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        logic [8:0] plan [PHASES];
        int settings_used;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        cmd = tlie_pkg::CMD_WRITE;
        entry_index = '0;
        x_value = '0;
        y_value = '0;
        calm = 1'b0;
        hold_seq = 0;
        active_points = 2;
        writes_sent = 0;
        queries_sent = 0;
        settings_used = 0;
        plan = '{9'd511, 9'd256, 9'd257, 9'd0, 9'd3, 9'd17, 9'd1, 9'd64, 9'd5, 9'd8,
                 9'd33, 9'd4, 9'd2};
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // two-point table at the reset count: regions and saturation
        put_point(8'd0, 32'sh0000_0000, 32'sh0000_0000);
        put_point(8'd1, 32'sh0001_0000, 32'sh0002_0000);
        ask(32'sh0000_0000);
        ask(32'sh0000_8000);
        ask(-32'sh0001_0000);
        ask(32'sh0002_0000);
        ask(32'sh8000_0000);
        ask(32'sh7FFF_FFFF);

        // full-scale slope over a unit step: clipping both ways
        put_point(8'd0, 32'sh0000_0000, 32'sh8000_0000);
        put_point(8'd1, 32'sh0000_0001, 32'sh7FFF_FFFF);
        ask(32'sh0000_0001);
        ask(-32'sh0000_0001);
        ask(32'sh7FFF_FFFF);

        // both points share x
        put_point(8'd0, 32'sh0000_0005, 32'sh0000_0064);
        put_point(8'd1, 32'sh0000_0005, -32'sh0000_0064);
        ask(32'sh0000_0005);
        ask(32'sh0000_0006);
        ask(32'sh0000_0004);
        put_point(8'd255, 32'sh7FFF_FFFF, 32'sh8000_0000);

        load_table(DEPTH, SHAPE_RAMP);

        for (int p = 0; p < PHASES; p++)
        begin
            set_count(plan[p]);
            settings_used++;
            calm = (p == 2);
            if (active_points <= 64)
                load_table(active_points, table_shape_t'($urandom_range(3)));
            if (p == 4)
                hold_seq++;
            for (int k = 0; k < QUERIES_PER_PHASE; k++)
            begin
                if ($urandom_range(9) == 0)
                    refresh_y();
                if ($urandom_range(29) == 0)
                    wait_drained();
                ask(pick_query());
            end
        end

        wait_drained();
        $display("Sent %0d queries and %0d table writes over %0d count settings, %0d checked",
                 queries_sent, writes_sent, settings_used, results_seen);
        $display("%0d results were clipped to range, %0d came from a zero-width interval",
                 sat_seen, zero_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
